@@ sv/byte_stream_bit_mix_hash_defines.svh @@
// Assertion macros shared by the byte stream bit mix hash RTL.
// No dependencies; the synthesis build defines SYNTHESIS and gets empty bodies.
`ifndef BYTE_STREAM_BIT_MIX_HASH_DEFINES_SVH
`define BYTE_STREAM_BIT_MIX_HASH_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked only while out of reset.
`define BSBMH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsbmh assertion failed");

// Next-cycle implication, checked only while out of reset.
`define BSBMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsbmh assertion failed");

`else

`define BSBMH_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BSBMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/bsbmh_pkg.sv @@
// Package for the byte stream bit mix hash: seed, widths and wiring tables.
// No dependencies; used by bsbmh_mix and the top level.
package bsbmh_pkg;

  localparam int unsigned MIX_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FLIPS  = 4;

  typedef logic [MIX_W-1:0]  mix_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [4:0]        mix_pos_t;
  typedef logic [2:0]        byte_pos_t;

  localparam mix_t MIX_SEED = 32'h83fd0ae1;

  // XOR network: new bit i takes mix bit XSRC[i] and byte bit XBYTE[i].
  localparam mix_pos_t XSRC [0:MIX_W-1] = '{
    5'd23, 5'd1,  5'd29, 5'd15, 5'd10, 5'd5,  5'd21, 5'd8,
    5'd3,  5'd17, 5'd9,  5'd28, 5'd12, 5'd4,  5'd22, 5'd2,
    5'd7,  5'd31, 5'd19, 5'd11, 5'd26, 5'd16, 5'd27, 5'd12,
    5'd20, 5'd6,  5'd18, 5'd24, 5'd14, 5'd20, 5'd25, 5'd13
  };
  localparam byte_pos_t XBYTE [0:MIX_W-1] = '{
    3'd7, 3'd3, 3'd1, 3'd0, 3'd5, 3'd2, 3'd6, 3'd4,
    3'd1, 3'd3, 3'd7, 3'd2, 3'd4, 3'd6, 3'd5, 3'd0,
    3'd4, 3'd0, 3'd5, 3'd6, 3'd2, 3'd3, 3'd7, 3'd1,
    3'd2, 3'd1, 3'd6, 3'd3, 3'd0, 3'd7, 3'd4, 3'd5
  };

  // Flip index bits, lowest first: byte, byte, mix, byte, byte.
  localparam byte_pos_t FLIP_B0  [0:FLIPS-1] = '{3'd7, 3'd1, 3'd2, 3'd6};
  localparam byte_pos_t FLIP_B1  [0:FLIPS-1] = '{3'd2, 3'd4, 3'd7, 3'd4};
  localparam mix_pos_t  FLIP_MIX [0:FLIPS-1] = '{5'd19, 5'd7, 5'd21, 5'd0};
  localparam byte_pos_t FLIP_B3  [0:FLIPS-1] = '{3'd0, 3'd6, 3'd1, 3'd5};
  localparam byte_pos_t FLIP_B4  [0:FLIPS-1] = '{3'd5, 3'd3, 3'd3, 3'd0};

endpackage

@@ sv/byte_stream_bit_mix_hash.sv @@
// Byte stream bit mix hash; a last byte passes the input stage, then the output stage.
// Throughput one byte word per clock while no last byte waits for the output stage.
// rst_n is synchronous, active low: it empties both stages and loads the seed
// 0x83fd0ae1 into the mix word and zero into the previous byte.
// Depends on bsbmh_pkg, bsbmh_mix and byte_stream_bit_mix_hash_defines.svh.
`include "byte_stream_bit_mix_hash_defines.svh"

module byte_stream_bit_mix_hash (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  bsbmh_pkg::byte_t       in_tdata,   // [7:0] key_byte
  input  logic                   in_tlast,   // last_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output bsbmh_pkg::mix_t        out_tdata   // [31:0] hash_value
);
  import bsbmh_pkg::*;

  // The input stage holds one accepted byte word. Its byte runs through the
  // mix network against the running state while it sits in the stage. A word
  // that is not the last of a key only updates the state, so it always
  // leaves the stage; a last word also needs the output register free (or
  // being drained) because it loads the finished hash there.

  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;
  logic  s1_last_r;
  mix_t  mix_r, mix_nxt;
  byte_t prev_r, prev_nxt;
  logic  out_valid_r, out_valid_nxt;
  mix_t  out_data_r;
  mix_t  mix_next;
  logic  s1_advance;
  logic  out_load;

  bsbmh_mix u_mix (
    .mix_word  (mix_r),
    .prev_byte (prev_r),
    .key_byte  (s1_byte_r),
    .mix_next  (mix_next)
  );

  assign out_load   = s1_valid_r && s1_last_r && (!out_valid_r || out_tready);
  assign s1_advance = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  always_comb begin
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = out_load || (out_valid_r && !out_tready);
    mix_nxt       = mix_r;
    prev_nxt      = prev_r;
    if (s1_advance) begin
      if (s1_last_r) begin
        // End of key: the state returns to its start values.
        mix_nxt  = MIX_SEED;
        prev_nxt = '0;
      end else begin
        mix_nxt  = mix_next;
        prev_nxt = s1_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mix_r       <= MIX_SEED;
      prev_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      mix_r       <= mix_nxt;
      prev_r      <= prev_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (out_load) begin
      out_data_r <= mix_next;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A finished key leaves the state at seed and zero byte.
  `BSBMH_ASSERT_NEXT(a_key_end_restart, clk, rst_n, s1_advance && s1_last_r,
    mix_r == MIX_SEED && prev_r == '0 && out_valid_r)
  // A middle byte becomes the previous byte for the next word.
  `BSBMH_ASSERT_NEXT(a_prev_follows, clk, rst_n, s1_advance && !s1_last_r,
    prev_r == $past(s1_byte_r))
  // A loaded hash is exactly the network result of the last byte.
  `BSBMH_ASSERT_NEXT(a_hash_loaded, clk, rst_n, out_load,
    out_data_r == $past(mix_next))
  // The state only moves when the input stage hands a byte on.
  `BSBMH_ASSERT_NEXT(a_state_holds, clk, rst_n, !s1_advance,
    mix_r == $past(mix_r) && prev_r == $past(prev_r))

endmodule

@@ sv/bsbmh_mix.sv @@
// Combinational mix network: flips by the previous byte, then XOR network and flips by the key byte.
// Depends on bsbmh_pkg for the wiring tables.
module bsbmh_mix (
  input  bsbmh_pkg::mix_t  mix_word,
  input  bsbmh_pkg::byte_t prev_byte,
  input  bsbmh_pkg::byte_t key_byte,
  output bsbmh_pkg::mix_t  mix_next
);
  import bsbmh_pkg::*;

  // Four flips in order; each index sees the word as left by the flip before.
  function automatic mix_t flip_round(input mix_t m_in, input byte_t b);
    mix_t     m;
    mix_pos_t idx;
    m = m_in;
    for (int k = 0; k < FLIPS; k++) begin
      idx    = {b[FLIP_B4[k]], b[FLIP_B3[k]], m[FLIP_MIX[k]], b[FLIP_B1[k]], b[FLIP_B0[k]]};
      m[idx] = ~m[idx];
    end
    return m;
  endfunction

  // Bits are rewritten low to high, so a source below i is already updated.
  function automatic mix_t xor_network(input mix_t m_in, input byte_t b);
    mix_t m;
    m = m_in;
    for (int i = 0; i < MIX_W; i++) begin
      m[i] = m[XSRC[i]] ^ b[XBYTE[i]];
    end
    return m;
  endfunction

  always_comb begin
    mix_next = flip_round(xor_network(flip_round(mix_word, prev_byte), key_byte), key_byte);
  end

endmodule
